@@ rtl/wtm_pkg.sv @@
// Package for the wildcard text matcher: word types, request codes, pattern view,
// and the byte helpers shared by the pattern store and the position tracker.
// No dependencies.
`timescale 1ns / 1ps

package wtm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

    localparam logic [7:0] STAR_CODE   = 8'h2A;
    localparam logic [7:0] SPACE_TOP   = 8'h20;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SOURCE = 2'd2,
        REQ_END    = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  char_code;
    } in_word_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } out_word_t;

    typedef struct packed {
        logic [PATTERN_MAX-1:0][7:0] entry;
        logic [PATTERN_MAX-1:0]      is_star;
        logic [PATTERN_MAX-1:0]      is_ws;
        logic [PATTERN_MAX-1:0]      in_use;
        logic [LEN_W-1:0]            len;
        logic                        overflow;
    } pat_view_t;

    function automatic logic is_space(input logic [7:0] c);
        return c <= SPACE_TOP;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= LOWER_A && c <= LOWER_Z) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    // Stars never sit next to each other in the store, so one level suffices.
    function automatic logic [PATTERN_MAX:0] closure(input logic [PATTERN_MAX:0] a,
                                                     input pat_view_t p);
        logic [PATTERN_MAX:0] c;
        c = a;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            c[i+1] = c[i+1] | (a[i] & p.is_star[i] & p.in_use[i]);
        end
        return c;
    endfunction

endpackage

@@ rtl/wildcard_text_matcher_core.sv @@
// Top level of the wildcard text matcher: input register, pattern store, position
// tracker and result register. Depends on wtm_pkg and the wtm_* modules.
`timescale 1ns / 1ps

// Load a pattern with clear and append words, then stream source bytes and close
// with an end-of-source word, which returns one result word (match flag and
// pattern overflow flag) and rearms for the next source. Each word is handled when
// it is taken: the active-position vector advances a full byte per cycle, including
// the extra whitespace step taken before a byte that ends a deferred whitespace run.
// Words flow at one per clock; an end-of-source word waits in the input register
// only while the result register still holds a word that has not been taken.
// The pattern holds up to PATTERN_MAX entries; there is no clearing pass.

module wildcard_text_matcher_core
    import wtm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    in_word_t  word;
    logic      word_valid;
    logic      take;
    logic      matched;
    pat_view_t pat;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg;

    assign take = word_valid && (word.req_type != REQ_END || !out_valid_reg || m_ready);

    wtm_input_reg u_input_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    wtm_pattern_store u_pattern_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (take),
        .word    (word),
        .pat     (pat)
    );

    wtm_position_tracker u_position_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (take),
        .word    (word),
        .pat     (pat),
        .matched (matched)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take && word.req_type == REQ_END) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && word.req_type == REQ_END) begin
            out_data_reg.matched          <= matched;
            out_data_reg.pattern_overflow <= pat.overflow;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(take && word.req_type == REQ_END))
        else $error("result word without end-of-source word");

endmodule

@@ rtl/wtm_input_reg.sv @@
// Input register of the wildcard text matcher: holds one word until the core takes it.
// Depends on wtm_pkg.
`timescale 1ns / 1ps

module wtm_input_reg
    import wtm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    input  logic     take,
    output logic     word_valid,
    output in_word_t word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign s_ready    = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_data;
        end
    end

endmodule

@@ rtl/wtm_pattern_store.sv @@
// Pattern store: trims, merges and upper-cases pattern bytes into the entry registers.
// Depends on wtm_pkg.
`timescale 1ns / 1ps

module wtm_pattern_store
    import wtm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      go,
    input  in_word_t  word,
    output pat_view_t pat
);

    logic [PATTERN_MAX-1:0][7:0] entry_reg;
    logic [LEN_W-1:0]            len_reg, len_next, len_mid;
    logic                        pend_reg, pend_next;
    logic                        ovf_reg, ovf_next;
    logic                        last_star_reg, last_star_next;
    logic                        wr_space, wr_char, star_mid;
    logic [7:0]                  upper;

    assign upper = to_upper(word.char_code);

    always_comb begin
        len_next       = len_reg;
        pend_next      = pend_reg;
        ovf_next       = ovf_reg;
        last_star_next = last_star_reg;
        len_mid        = len_reg;
        star_mid       = last_star_reg;
        wr_space       = 1'b0;
        wr_char        = 1'b0;
        if (go) begin
            unique case (word.req_type)
                REQ_CLEAR: begin
                    len_next       = '0;
                    pend_next      = 1'b0;
                    ovf_next       = 1'b0;
                    last_star_next = 1'b0;
                end
                REQ_APPEND: begin
                    if (is_space(word.char_code)) begin
                        if (len_reg != '0) begin
                            pend_next = 1'b1;
                        end
                    end else begin
                        if (pend_reg) begin
                            pend_next = 1'b0;
                            if (len_reg < LEN_W'(PATTERN_MAX)) begin
                                wr_space = 1'b1;
                                len_mid  = len_reg + LEN_W'(1);
                                star_mid = 1'b0;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        len_next       = len_mid;
                        last_star_next = star_mid;
                        if (!(upper == STAR_CODE && star_mid)) begin
                            if (len_mid < LEN_W'(PATTERN_MAX)) begin
                                wr_char        = 1'b1;
                                len_next       = len_mid + LEN_W'(1);
                                last_star_next = (upper == STAR_CODE);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            last_star_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            ovf_reg       <= ovf_next;
            last_star_reg <= last_star_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (wr_space && len_reg == LEN_W'(j)) begin
                entry_reg[j] <= SPACE_TOP;
            end
            if (wr_char && len_mid == LEN_W'(j)) begin
                entry_reg[j] <= upper;
            end
        end
    end

    always_comb begin
        pat.entry    = entry_reg;
        pat.len      = len_reg;
        pat.overflow = ovf_reg;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            pat.is_star[j] = (entry_reg[j] == STAR_CODE);
            pat.is_ws[j]   = is_space(entry_reg[j]);
            pat.in_use[j]  = (LEN_W'(j) < len_reg);
        end
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond store");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> len_reg == LEN_W'(PATTERN_MAX))
        else $error("overflow flagged with room left in store");

endmodule

@@ rtl/wtm_position_tracker.sv @@
// Position tracker: bit vector of active pattern positions, advanced per source byte,
// with deferred whitespace handling. Depends on wtm_pkg.
`timescale 1ns / 1ps

module wtm_position_tracker
    import wtm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      go,
    input  in_word_t  word,
    input  pat_view_t pat,
    output logic      matched
);

    localparam logic [PATTERN_MAX:0] ARMED = (PATTERN_MAX+1)'(1);

    logic [PATTERN_MAX:0] act_reg, act_next, act_mid, act_closed;
    logic                 seen_reg, seen_next;
    logic                 pend_reg, pend_next;

    function automatic logic [PATTERN_MAX:0] advance(input logic [PATTERN_MAX:0] a_raw,
                                                     input logic [7:0] c,
                                                     input pat_view_t p);
        logic [PATTERN_MAX:0] a;
        logic [PATTERN_MAX:0] nxt;
        logic                 ws;
        logic [7:0]           u;
        a   = closure(a_raw, p);
        ws  = is_space(c);
        u   = to_upper(c);
        nxt = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            nxt[j+1] = nxt[j+1] | (a[j+1] & ws & p.is_ws[j]);
            if (p.in_use[j]) begin
                nxt[j] = nxt[j] | (a[j] & p.is_star[j]);
                if (p.is_ws[j]) begin
                    nxt[j+1] = nxt[j+1] | (a[j] & ws);
                end else if (!p.is_star[j] && !ws && u == p.entry[j]) begin
                    nxt[j+1] = nxt[j+1] | a[j];
                end
            end
        end
        return nxt;
    endfunction

    assign act_closed = closure(act_reg, pat);
    assign matched    = act_closed[pat.len];
    assign act_mid    = pend_reg ? advance(act_reg, SPACE_TOP, pat) : act_reg;

    always_comb begin
        act_next  = act_reg;
        seen_next = seen_reg;
        pend_next = pend_reg;
        if (go) begin
            unique case (word.req_type)
                REQ_SOURCE: begin
                    if (is_space(word.char_code)) begin
                        if (seen_reg) begin
                            pend_next = 1'b1;
                        end
                    end else begin
                        act_next  = advance(act_mid, word.char_code, pat);
                        pend_next = 1'b0;
                        seen_next = 1'b1;
                    end
                end
                default: begin
                    act_next  = ARMED;
                    seen_next = 1'b0;
                    pend_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg  <= ARMED;
            seen_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            act_reg  <= act_next;
            seen_reg <= seen_next;
            pend_reg <= pend_next;
        end
    end

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        go && word.req_type != REQ_SOURCE |=> act_reg == ARMED && !seen_reg && !pend_reg)
        else $error("source side not rearmed");

    a_within_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (act_reg >> pat.len) <= ARMED)
        else $error("active position beyond pattern end");

endmodule
